>>> hw/rtl/cpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg: shared definitions for the contrast pixel counter
// Field widths, register indexes, reset values and the contrast compare.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int PIXEL_W = 8;
    localparam int COUNT_W = 20;

    localparam int THRESHOLD_W    = 8;
    localparam int FRAME_WIDTH_W  = 10;
    localparam int FRAME_HEIGHT_W = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FRAME_HEIGHT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RST    = 8'd128;
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 10'd320;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 11'd200;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int MIN_SIDE = 2;

    // One line store entry: pixel of the row above and its partial flag
    typedef struct packed {
        logic [PIXEL_W-1:0] pix;
        logic               flag;
    } t_line_word;

    localparam int LINE_WORD_W = $bits(t_line_word);

    // Per-pixel position flags carried into the compute stage
    typedef struct packed {
        logic first_col;
        logic last_col;
        logic last_row;
        logic row_nz;
    } t_pos;

    function automatic logic exceeds(input logic [PIXEL_W-1:0]     a,
                                     input logic [PIXEL_W-1:0]     b,
                                     input logic [THRESHOLD_W-1:0] th);
        logic [PIXEL_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > th;
    endfunction

endpackage

>>> hw/rtl/cpc_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pixel_if: pixel stream channel
// Valid/ready channel carrying one grayscale pixel per beat.
// ----------------------------------------------------------------------------
interface cpc_pixel_if import cpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

>>> hw/rtl/cpc_count_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_count_if: frame result channel
// Valid/ready channel carrying one contrast pixel count per beat.
// ----------------------------------------------------------------------------
interface cpc_count_if import cpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] contrast_count;

    modport source (output valid, output contrast_count, input ready);
    modport sink (input valid, input contrast_count, output ready);
endinterface

>>> hw/rtl/cpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_ram: simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module cpc_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/contrast_pixel_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_pixel_counter: four-neighbor contrast pixel count per frame
// Counts pixels with a 4-neighbor differing by more than the threshold and
// emits the count at the last pixel of each frame.
// ----------------------------------------------------------------------------
//  channel  | dir | beat payload           | note
//  ---------+-----+------------------------+---------------------------------
//  i_pix    | in  | pixel [7:0]            | raster order, one pixel a beat
//  o_cnt    | out | contrast_count [19:0]  | one beat at each frame end
//  i_cfg_*  | in  | idx [1:0], data [10:0] | write-only, taken when i_cfg_we
//
//  One pixel per cycle while i_pix.ready is high. A pixel is read from the
//  line store in the accept cycle and evaluated in stage 1; the single
//  write port takes the left neighbor's entry, and a row's last entry in
//  the next cycle. Reset clears counters, position and the output register;
//  the line store is not cleared and is filled by the first row of a frame.
//  i_pix.ready drops only while a frame result waits in the output register
//  and the last pixel of the next frame is ready to complete.
// ----------------------------------------------------------------------------
module contrast_pixel_counter import cpc_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpc_pixel_if.sink             i_pix,
    cpc_count_if.source           o_cnt,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration
    logic [THRESHOLD_W-1:0]    r_threshold;
    logic [FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RST;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD:    r_threshold    <= i_cfg_data[THRESHOLD_W-1:0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped geometry
    logic [COL_W:0] w_lim;
    logic [ROW_W:0] h_lim;

    always_comb begin
        if (r_frame_width < MIN_SIDE) begin
            w_lim = (COL_W+1)'(MIN_SIDE);
        end else if (r_frame_width > MAX_WIDTH) begin
            w_lim = (COL_W+1)'(MAX_WIDTH);
        end else begin
            w_lim = (COL_W+1)'(r_frame_width);
        end
        if (r_frame_height < MIN_SIDE) begin
            h_lim = (ROW_W+1)'(MIN_SIDE);
        end else if (r_frame_height > MAX_HEIGHT) begin
            h_lim = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            h_lim = (ROW_W+1)'(r_frame_height);
        end
    end

    // Stage 0: position and line store read
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             accept;
    t_pos             s0_pos;

    assign accept = i_pix.valid && i_pix.ready;

    always_comb begin
        s0_pos.first_col = (r_col == '0);
        s0_pos.last_col  = (({1'b0, r_col} + (COL_W+1)'(1)) >= w_lim);
        s0_pos.last_row  = (({1'b0, r_row} + (ROW_W+1)'(1)) >= h_lim);
        s0_pos.row_nz    = (r_row != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (s0_pos.last_col) begin
                r_col <= '0;
                r_row <= s0_pos.last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Line store write port
    logic             ram_we;
    logic [COL_W-1:0] ram_waddr;
    t_line_word       ram_wdata;
    t_line_word       ram_rdata;

    cpc_ram #(
        .WIDTH (LINE_WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Stage 1 registers
    logic               r_s1_valid;
    t_pos               r_s1_pos;
    logic [COL_W-1:0]   r_s1_col;
    logic [PIXEL_W-1:0] r_s1_pixel;
    logic               r_s1_fwd;
    t_line_word         r_fwd_word;

    logic [PIXEL_W-1:0] r_left_pixel;
    logic               r_left_flag;
    logic [COUNT_W-1:0] r_count;

    logic               r_pend_valid;
    logic [COL_W-1:0]   r_pend_addr;
    t_line_word         r_pend_word;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    // Stage 1: evaluate
    t_line_word         up_word;
    logic               d_up;
    logic               d_left;
    logic               f;
    logic               lf_new;
    logic               emit;
    logic [1:0]         inc;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] n_count;
    logic               adv1;
    logic               s1_fire;
    logic               left_wr;
    logic               n_pend_valid;

    always_comb begin
        up_word = r_s1_fwd ? r_fwd_word : ram_rdata;
        d_up    = r_s1_pos.row_nz && exceeds(r_s1_pixel, up_word.pix, r_threshold);
        d_left  = !r_s1_pos.first_col && exceeds(r_s1_pixel, r_left_pixel, r_threshold);
        f       = d_up || d_left;
        lf_new  = r_left_flag || d_left;
        emit    = r_s1_pos.last_col && r_s1_pos.last_row;
        // pixel above final, left pixel final in the last row, frame's last pixel
        inc = {1'b0, r_s1_pos.row_nz && (up_word.flag || d_up)}
            + {1'b0, !r_s1_pos.first_col && r_s1_pos.last_row && lf_new}
            + {1'b0, emit && f};
        sum     = {1'b0, r_count} + (COUNT_W+1)'(inc);
        n_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];

        // hold when a frame result cannot be parked
        adv1    = !(r_s1_valid && emit && r_out_valid && !o_cnt.ready);
        s1_fire = r_s1_valid && adv1;
        left_wr = s1_fire && !r_s1_pos.first_col;

        // left neighbor entry first, a row's last entry on the next free cycle
        ram_we         = left_wr || r_pend_valid;
        ram_waddr      = r_pend_addr;
        ram_wdata      = r_pend_word;
        n_pend_valid   = 1'b0;
        if (left_wr) begin
            ram_waddr     = r_s1_col - COL_W'(1);
            ram_wdata.pix = r_left_pixel;
            ram_wdata.flag = lf_new;
            n_pend_valid  = r_pend_valid;
        end
        if (s1_fire && r_s1_pos.last_col) begin
            n_pend_valid = 1'b1;
        end
    end

    assign i_pix.ready          = adv1;
    assign o_cnt.valid          = r_out_valid;
    assign o_cnt.contrast_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_left_pixel <= '0;
            r_left_flag  <= 1'b0;
            r_count      <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                if (r_s1_pos.last_col) begin
                    r_left_pixel <= '0;
                    r_left_flag  <= 1'b0;
                end else begin
                    r_left_pixel <= r_s1_pixel;
                    r_left_flag  <= f;
                end
                r_count <= emit ? '0 : n_count;
            end
            if (s1_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_cnt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos   <= s0_pos;
            r_s1_col   <= r_col;
            r_s1_pixel <= i_pix.pixel;
            // forward a write to the entry being read in the same cycle
            r_s1_fwd   <= ram_we && (ram_waddr == r_col);
            r_fwd_word <= ram_wdata;
        end
        if (s1_fire && r_s1_pos.last_col) begin
            r_pend_addr      <= r_s1_col;
            r_pend_word.pix  <= r_s1_pixel;
            r_pend_word.flag <= f;
        end
        if (s1_fire && emit) begin
            r_out_count <= n_count;
        end
    end

    // Assertions
    a_pend_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |=> !r_pend_valid)
        else $error("row end write not flushed in the following cycle");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && emit) |=> (r_count == '0))
        else $error("running count not cleared after frame end");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_pos.last_col && r_s1_pos.last_row))
        else $error("result produced without a frame's last pixel");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_cnt.ready) |=> (r_out_valid && $stable(r_out_count)))
        else $error("waiting result lost or changed");

    a_no_left_write_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_pos.last_col) |-> !r_s1_pos.first_col)
        else $error("row end on the first column");

endmodule

>>> sim/contrast_pixel_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_pixel_counter_tb: self-checking bench for the contrast counter
// Streams grayscale frames of varied size, threshold and texture through the
// pixel channel. A predictor tracks the line store, counts the contrast pixels
// of each frame and queues the totals. Each count beat is checked against the
// oldest total, under random stalls on both channels.
// ----------------------------------------------------------------------------
module contrast_pixel_counter_tb;
    import cpc_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 240;
    localparam int REPORT_LIMIT  = 10;

    typedef enum int {FILL_UNIFORM, FILL_NEAR, FILL_EXTREME, FILL_SPIKE} t_fill;

    // Tracks the frame state and keeps the counts still owed by the block
    class t_contrast_tally;
        logic [THRESHOLD_W-1:0]    threshold;
        logic [FRAME_WIDTH_W-1:0]  frame_width;
        logic [FRAME_HEIGHT_W-1:0] frame_height;
        logic [PIXEL_W-1:0]        row_pix [MAX_WIDTH_DEF];
        bit                        row_flag [MAX_WIDTH_DEF];
        logic [PIXEL_W-1:0]        left_pix;
        bit                        left_flag;
        logic [8:0]                column;
        logic [9:0]                row;
        logic [COUNT_W-1:0]        running;
        logic [COUNT_W-1:0]        frame_counts [$];
        int                        errors;

        function new();
            threshold    = THRESHOLD_RST;
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            foreach (row_pix[k]) begin
                row_pix[k]  = '0;
                row_flag[k] = 1'b0;
            end
            left_pix  = '0;
            left_flag = 1'b0;
            column    = '0;
            row       = '0;
            running   = '0;
            errors    = 0;
        endfunction

        function int unsigned clamp_side(int unsigned v, int unsigned hi);
            if (v < MIN_SIDE) return MIN_SIDE;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned pixels_per_frame();
            return clamp_side(frame_width, MAX_WIDTH_DEF) *
                   clamp_side(frame_height, MAX_HEIGHT_DEF);
        endfunction

        function bit contrasts(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b);
            int d;
            d = int'(a) - int'(b);
            if (d < 0) d = -d;
            return d > int'(threshold);
        endfunction

        function void count_one();
            if (running != '1) running++;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_THRESHOLD:    threshold    = val[THRESHOLD_W-1:0];
                CFG_FRAME_WIDTH:  frame_width  = val[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: frame_height = val[FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] p);
            int unsigned w, h, c;
            bit last_col, last_row, f;
            w = clamp_side(frame_width, MAX_WIDTH_DEF);
            h = clamp_side(frame_height, MAX_HEIGHT_DEF);
            c = column;
            last_col = (c + 1 >= w);
            last_row = (row + 1 >= h);
            f = 1'b0;
            // pixel above becomes final here
            if (row != 0) begin
                if (contrasts(p, row_pix[c])) f = 1'b1;
                if (row_flag[c] || f) count_one();
            end
            if (c != 0) begin
                if (contrasts(p, left_pix)) begin
                    f = 1'b1;
                    left_flag = 1'b1;
                end
                // no row below: the left pixel is final now
                if (last_row) begin
                    if (left_flag) count_one();
                end else begin
                    row_flag[c - 1] = left_flag;
                end
            end
            row_pix[c] = p;
            if (last_col) row_flag[c] = f;
            if (last_col && last_row) begin
                if (f) count_one();
                frame_counts.push_back(running);
                running   = '0;
                column    = '0;
                row       = '0;
                left_pix  = '0;
                left_flag = 1'b0;
            end else if (last_col) begin
                column    = '0;
                row       = row + 1'b1;
                left_pix  = '0;
                left_flag = 1'b0;
            end else begin
                column    = column + 1'b1;
                left_pix  = p;
                left_flag = f;
            end
        endfunction

        function void check_count(logic [COUNT_W-1:0] got);
            logic [COUNT_W-1:0] want;
            if (frame_counts.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("count beat with no frame pending: got %0d", got);
                return;
            end
            want = frame_counts.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("contrast_count wrong: expected %0d, actual %0d", want, got);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int src_idle_pct = 21;
    int snk_idle_pct = 72;
    int hold_seq     = 0;

    t_contrast_tally tally = new();

    cpc_pixel_if pix_if ();
    cpc_count_if cnt_if ();

    contrast_pixel_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_cnt      (cnt_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin : count_sink
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        cnt_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen) begin
                seen = hold_seq;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                cnt_if.ready <= 1'b0;
            end else begin
                cnt_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cnt_if.valid && cnt_if.ready)
            tally.check_count(cnt_if.contrast_count);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (cnt_if.valid && cnt_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("contrast_pixel_counter: mismatch");
        $finish;
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] p);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= p;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        tally.note_pixel(p);
    endtask

    task automatic send_list(input logic [PIXEL_W-1:0] px [$]);
        foreach (px[k]) send_pixel(px[k]);
    endtask

    // Drop valid, wait out the owed counts, then let the pipeline drain
    task automatic go_idle();
        pix_if.valid <= 1'b0;
        while (tally.frame_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        tally.set_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input int unsigned th, input int unsigned w,
                             input int unsigned h);
        write_reg(CFG_THRESHOLD, th);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel(t_fill mode, int base);
        int v;
        case (mode)
            FILL_NEAR:    v = base + int'($urandom_range(0, 24)) - 12;
            FILL_EXTREME: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
            FILL_SPIKE:   v = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 255)) : base;
            default:      v = $urandom_range(0, 255);
        endcase
        if (v < 0) v = 0;
        else if (v > 255) v = 255;
        return v[PIXEL_W-1:0];
    endfunction

    task automatic send_frame(input t_fill mode, input int base);
        int unsigned n;
        n = tally.pixels_per_frame();
        for (int unsigned i = 0; i < n; i++) send_pixel(pick_pixel(mode, base));
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int quota);
        int sent, frames;
        int unsigned th, w, h;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < quota) begin
            go_idle();
            case ($urandom_range(0, 7))
                0:       th = 0;
                1:       th = 255;
                2, 3:    th = $urandom_range(0, 255);
                default: th = $urandom_range(0, 40);
            endcase
            case ($urandom_range(0, 15))
                0:       w = $urandom_range(0, 1);
                1:       w = $urandom_range(9, 32);
                default: w = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 15))
                0:       h = $urandom_range(0, 1);
                1:       h = $urandom_range(7, 12);
                default: h = $urandom_range(2, 6);
            endcase
            configure(th, w, h);
            frames = $urandom_range(1, 4);
            for (int k = 0; k < frames && sent < quota; k++) begin
                send_frame(t_fill'($urandom_range(0, 3)), $urandom_range(0, 255));
                sent += int'(tally.pixels_per_frame());
            end
        end
    endtask

    initial begin : stimulus
        logic [PIXEL_W-1:0] seq [$];
        i_rst_n      <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_THRESHOLD;
        cfg_data     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero threshold: any difference at all marks contrast
        configure(0, 2, 2);
        seq = {8'd0, 8'd0, 8'd0, 8'd1};
        send_list(seq);
        // full-scale step does not exceed the top threshold
        go_idle();
        configure(255, 2, 2);
        seq = {8'd0, 8'd255, 8'd255, 8'd0};
        send_list(seq);
        go_idle();
        configure(254, 2, 2);
        seq = {8'd255, 8'd0, 8'd0, 8'd255};
        send_list(seq);
        // width and height below range clamp to two
        go_idle();
        configure(100, 0, 1);
        seq = {8'd0, 8'd200, 8'd50, 8'd150};
        send_list(seq);
        // shrink geometry and move threshold mid-frame, inside the second row
        go_idle();
        configure(10, 4, 3);
        seq = {8'd0, 8'd20, 8'd40, 8'd60, 8'd5, 8'd50};
        send_list(seq);
        go_idle();
        configure(30, 2, 2);
        seq = {8'd90};
        send_list(seq);

        run_phase(21, 72, RANDOM_ITEMS / 3);
        run_phase(72, 21, RANDOM_ITEMS / 3);
        run_phase(0, 0, RANDOM_ITEMS / 3);

        // tiny frames against a stalled receiver fill the block
        go_idle();
        configure(20, 2, 2);
        hold_seq++;
        repeat (12) send_frame(FILL_UNIFORM, 0);

        // widest row from raw values past the top, then close the frame early
        go_idle();
        configure($urandom_range(0, 40), 1023, 2047);
        for (int k = 0; k < MAX_WIDTH_DEF; k++) send_pixel(pick_pixel(FILL_NEAR, 128));
        go_idle();
        configure($urandom_range(0, 40), 2, 2);
        send_pixel(pick_pixel(FILL_NEAR, 128));
        send_pixel(pick_pixel(FILL_NEAR, 128));

        go_idle();
        if (tally.errors == 0 && tally.frame_counts.size() == 0)
            $display("contrast_pixel_counter: match");
        else
            $display("contrast_pixel_counter: mismatch");
        $finish;
    end

endmodule
